/* design/cbwr_pkg.sv */
`timescale 1ns / 1ps

package cbwr_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RUN     = 2'd1,
    OP_TAKE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [1:0] POLL_BUSY     = 2'd0;
  localparam logic [1:0] POLL_COMPLETE = 2'd1;

  localparam logic [CfgIdxW-1:0] CFG_ATTACHED   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUSY_LIMIT = 2'd1;

  localparam logic [CountW-1:0] BUSY_LIMIT_RST = 10'd500;
  localparam logic [CountW-1:0] COUNT_MAX      = 10'd1023;

endpackage

/* design/callback_write_retry_fsm.sv */
`timescale 1ns / 1ps

// Latency: a result is registered and shown in the cycle after its input transaction is taken.
// Throughput: one transaction per cycle; the single output register is
// refilled in the same cycle it is drained, so in_ready follows out_ready.
// Configuration writes take effect at once; cfg_ready is always high.
// Reset (rst_n low, synchronous): phase idle, id, busy count, completion
// latch and output valid clear; transport detached, busy limit 500.
module callback_write_retry_fsm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_op,
  input  logic [cbwr_pkg::IdW-1:0]         in_report_id,
  input  logic [1:0]                       in_poll_status,
  input  logic                             in_owner_granted,
  input  logic                             in_write_queued,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_ack_taken,
  output logic                             out_do_claim,
  output logic                             out_do_poll,
  output logic                             out_do_release,
  output logic                             out_do_fail,
  output logic                             out_do_write,
  output logic [cbwr_pkg::IdW-1:0]         out_target_id,
  output logic [cbwr_pkg::PhaseW-1:0]      out_phase_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbwr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cbwr_pkg::CountW-1:0]      cfg_data
);

  typedef enum logic [cbwr_pkg::PhaseW-1:0] {
    PH_IDLE     = 3'd0,
    PH_READY    = 3'd1,
    PH_PENDING  = 3'd2,
    PH_ERROR    = 3'd3,
    PH_RECOVERY = 3'd4
  } phase_t;

  typedef struct packed {
    logic accepted;
    logic ack_taken;
    logic do_claim;
    logic do_poll;
    logic do_release;
    logic do_fail;
    logic do_write;
  } strobe_t;

  phase_t                      phase_r, phase_nxt;
  logic [cbwr_pkg::IdW-1:0]    held_id_r, held_id_nxt;
  logic [cbwr_pkg::CountW-1:0] busy_count_r, busy_count_nxt;
  logic                        ack_latch_r, ack_latch_nxt;
  logic                        attached_r;
  logic [cbwr_pkg::CountW-1:0] busy_limit_r;
  logic                        out_valid_r;
  strobe_t                     strobe_r, strobe_nxt;
  logic [cbwr_pkg::IdW-1:0]    target_id_r;
  logic [cbwr_pkg::PhaseW-1:0] phase_now_r;
  logic [cbwr_pkg::CountW:0]   busy_inc;
  logic                        in_fire;
  cbwr_pkg::op_t               op;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign op        = cbwr_pkg::op_t'(in_op);
  assign busy_inc  = {1'b0, busy_count_r} + {{cbwr_pkg::CountW{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt      = phase_r;
    held_id_nxt    = held_id_r;
    busy_count_nxt = busy_count_r;
    ack_latch_nxt  = ack_latch_r;
    strobe_nxt     = '0;
    case (op)
      cbwr_pkg::OP_REQUEST: begin
        if (attached_r && (in_report_id != '0)) begin
          strobe_nxt.accepted = 1'b1;
          if (phase_r == PH_IDLE) begin
            held_id_nxt    = in_report_id;
            busy_count_nxt = '0;
            phase_nxt      = PH_READY;
          end else if (phase_r == PH_READY) begin
            held_id_nxt = in_report_id;
          end
        end
      end
      cbwr_pkg::OP_RUN: begin
        if (attached_r && (phase_r != PH_IDLE)) begin
          case (phase_r)
            PH_ERROR: begin
              strobe_nxt.do_poll = 1'b1;
              if (in_poll_status != cbwr_pkg::POLL_BUSY) begin
                strobe_nxt.do_release = 1'b1;
                busy_count_nxt        = '0;
                phase_nxt             = PH_RECOVERY;
              end
            end
            PH_RECOVERY: begin
              phase_nxt = PH_READY;
            end
            PH_PENDING: begin
              strobe_nxt.do_poll = 1'b1;
              if (in_poll_status == cbwr_pkg::POLL_BUSY) begin
                busy_count_nxt = busy_inc[cbwr_pkg::CountW] ? cbwr_pkg::COUNT_MAX
                                                             : busy_inc[cbwr_pkg::CountW-1:0];
                if (busy_inc > {1'b0, busy_limit_r}) begin
                  strobe_nxt.do_fail = 1'b1;
                  phase_nxt          = PH_ERROR;
                end
              end else begin
                busy_count_nxt        = '0;
                strobe_nxt.do_release = 1'b1;
                if (in_poll_status == cbwr_pkg::POLL_COMPLETE) begin
                  ack_latch_nxt = 1'b1;
                  phase_nxt     = PH_IDLE;
                end else begin
                  phase_nxt = PH_ERROR;
                end
              end
            end
            default: begin
              strobe_nxt.do_claim = 1'b1;
              if (in_owner_granted) begin
                strobe_nxt.do_poll = 1'b1;
                if (in_poll_status == cbwr_pkg::POLL_COMPLETE) begin
                  strobe_nxt.do_write = 1'b1;
                  if (in_write_queued) begin
                    busy_count_nxt = '0;
                    phase_nxt      = PH_PENDING;
                  end else begin
                    phase_nxt = PH_ERROR;
                  end
                end
              end
            end
          endcase
        end
      end
      cbwr_pkg::OP_TAKE: begin
        if (ack_latch_r) begin
          strobe_nxt.ack_taken = 1'b1;
          ack_latch_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_id_r    <= '0;
      busy_count_r <= '0;
      ack_latch_r  <= 1'b0;
      attached_r   <= 1'b0;
      busy_limit_r <= cbwr_pkg::BUSY_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cbwr_pkg::CFG_ATTACHED) begin
          attached_r <= cfg_data[0];
        end else if (cfg_index == cbwr_pkg::CFG_BUSY_LIMIT) begin
          busy_limit_r <= cfg_data;
        end
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        held_id_r    <= held_id_nxt;
        busy_count_r <= busy_count_nxt;
        ack_latch_r  <= ack_latch_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      strobe_r    <= strobe_nxt;
      target_id_r <= held_id_nxt;
      phase_now_r <= phase_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = strobe_r.accepted;
  assign out_ack_taken  = strobe_r.ack_taken;
  assign out_do_claim   = strobe_r.do_claim;
  assign out_do_poll    = strobe_r.do_poll;
  assign out_do_release = strobe_r.do_release;
  assign out_do_fail    = strobe_r.do_fail;
  assign out_do_write   = strobe_r.do_write;
  assign out_target_id  = target_id_r;
  assign out_phase_now  = phase_now_r;

endmodule

/* design/cbwr_checker.sv */
`timescale 1ns / 1ps

module cbwr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_accepted,
  input logic                        out_ack_taken,
  input logic                        out_do_claim,
  input logic                        out_do_poll,
  input logic                        out_do_write,
  input logic [cbwr_pkg::PhaseW-1:0] out_phase_now
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase_now))
    else $error("result transaction changed while stalled");

  a_accept_only_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != cbwr_pkg::OP_REQUEST) |=> out_valid && !out_accepted)
    else $error("accepted flagged for a non-request transaction");

  a_take_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == cbwr_pkg::OP_TAKE)
      |=> !out_do_claim && !out_do_poll && !out_do_write)
    else $error("transport command issued on a take transaction");

  a_write_needs_claim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_do_write |-> out_do_claim && out_do_poll && !out_ack_taken)
    else $error("write issued without claim and poll");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind callback_write_retry_fsm cbwr_checker u_cbwr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_accepted  (out_accepted),
  .out_ack_taken (out_ack_taken),
  .out_do_claim  (out_do_claim),
  .out_do_poll   (out_do_poll),
  .out_do_write  (out_do_write),
  .out_phase_now (out_phase_now)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cbwr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_READY    = 3'd1,
    PH_PENDING  = 3'd2,
    PH_ERROR    = 3'd3,
    PH_RECOVERY = 3'd4
  } seq_phase_t;

  localparam logic [1:0] POLL_FAILED = 2'd2;
  localparam logic [1:0] POLL_ODD    = 2'd3;

  typedef struct packed {
    logic              accepted;
    logic              ack_taken;
    logic              do_claim;
    logic              do_poll;
    logic              do_release;
    logic              do_fail;
    logic              do_write;
    logic [IdW-1:0]    target_id;
    logic [PhaseW-1:0] phase_now;
  } strobe_t;

  class callback_tracker;
    bit                attached;
    logic [CountW-1:0] limit;
    seq_phase_t        phase;
    logic [IdW-1:0]    held_id;
    logic [CountW-1:0] busy_count;
    bit                ack_latch;
    strobe_t           strobe_q[$];
    int                errors;
    int                n_ops;
    int                n_results;
    int                n_writes;
    int                n_timeouts;
    int                n_acks;
    int                peak_busy;

    function new();
      attached   = 1'b0;
      limit      = BUSY_LIMIT_RST;
      phase      = PH_IDLE;
      held_id    = '0;
      busy_count = '0;
      ack_latch  = 1'b0;
      errors     = 0;
      n_ops      = 0;
      n_results  = 0;
      n_writes   = 0;
      n_timeouts = 0;
      n_acks     = 0;
      peak_busy  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] data);
      if (idx == CFG_ATTACHED) begin
        attached = data[0];
      end else if (idx == CFG_BUSY_LIMIT) begin
        limit = data;
      end
    endfunction

    function void note_op(op_t op, logic [IdW-1:0] rid, logic [1:0] poll,
                          logic owner, logic queued);
      strobe_t         e;
      logic [CountW:0] nxt;
      e = '0;
      n_ops++;
      case (op)
        OP_REQUEST: begin
          if (attached && rid != '0) begin
            e.accepted = 1'b1;
            if (phase == PH_IDLE) begin
              held_id    = rid;
              busy_count = '0;
              phase      = PH_READY;
            end else if (phase == PH_READY) begin
              held_id = rid;
            end
          end
        end
        OP_RUN: begin
          if (attached && phase != PH_IDLE) begin
            case (phase)
              PH_ERROR: begin
                e.do_poll = 1'b1;
                if (poll != POLL_BUSY) begin
                  e.do_release = 1'b1;
                  busy_count   = '0;
                  phase        = PH_RECOVERY;
                end
              end
              PH_RECOVERY: begin
                phase = PH_READY;
              end
              PH_PENDING: begin
                e.do_poll = 1'b1;
                if (poll == POLL_BUSY) begin
                  nxt = {1'b0, busy_count} + 1'b1;
                  busy_count = (nxt > {1'b0, COUNT_MAX}) ? COUNT_MAX : nxt[CountW-1:0];
                  if (busy_count > peak_busy) peak_busy = busy_count;
                  if (nxt > {1'b0, limit}) begin
                    e.do_fail = 1'b1;
                    phase     = PH_ERROR;
                    n_timeouts++;
                  end
                end else begin
                  busy_count   = '0;
                  e.do_release = 1'b1;
                  if (poll == POLL_COMPLETE) begin
                    ack_latch = 1'b1;
                    phase     = PH_IDLE;
                  end else begin
                    phase = PH_ERROR;
                  end
                end
              end
              default: begin
                e.do_claim = 1'b1;
                if (owner) begin
                  e.do_poll = 1'b1;
                  if (poll == POLL_COMPLETE) begin
                    e.do_write = 1'b1;
                    n_writes++;
                    if (queued) begin
                      busy_count = '0;
                      phase      = PH_PENDING;
                    end else begin
                      phase = PH_ERROR;
                    end
                  end
                end
              end
            endcase
          end
        end
        OP_TAKE: begin
          if (ack_latch) begin
            e.ack_taken = 1'b1;
            ack_latch   = 1'b0;
            n_acks++;
          end
        end
        default: ;
      endcase
      e.target_id = held_id;
      e.phase_now = phase;
      strobe_q.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(strobe_t got);
      strobe_t want;
      if (strobe_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      want = strobe_q.pop_front();
      n_results++;
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("ack_taken", want.ack_taken, got.ack_taken);
      compare_field("do_claim", want.do_claim, got.do_claim);
      compare_field("do_poll", want.do_poll, got.do_poll);
      compare_field("do_release", want.do_release, got.do_release);
      compare_field("do_fail", want.do_fail, got.do_fail);
      compare_field("do_write", want.do_write, got.do_write);
      compare_field("target_id", want.target_id, got.target_id);
      compare_field("phase_now", want.phase_now, got.phase_now);
    endfunction

    function int outstanding();
      return strobe_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = '0;
  logic [IdW-1:0]     in_report_id = '0;
  logic [1:0]         in_poll_status = '0;
  logic               in_owner_granted = 1'b0;
  logic               in_write_queued = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_accepted;
  logic               out_ack_taken;
  logic               out_do_claim;
  logic               out_do_poll;
  logic               out_do_release;
  logic               out_do_fail;
  logic               out_do_write;
  logic [IdW-1:0]     out_target_id;
  logic [PhaseW-1:0]  out_phase_now;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CountW-1:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  callback_tracker sb;

  callback_write_retry_fsm dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_report_id     (in_report_id),
    .in_poll_status   (in_poll_status),
    .in_owner_granted (in_owner_granted),
    .in_write_queued  (in_write_queued),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_ack_taken    (out_ack_taken),
    .out_do_claim     (out_do_claim),
    .out_do_poll      (out_do_poll),
    .out_do_release   (out_do_release),
    .out_do_fail      (out_do_fail),
    .out_do_write     (out_do_write),
    .out_target_id    (out_target_id),
    .out_phase_now    (out_phase_now),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    strobe_t got;
    if (rst_n && out_valid && out_ready) begin
      got.accepted   = out_accepted;
      got.ack_taken  = out_ack_taken;
      got.do_claim   = out_do_claim;
      got.do_poll    = out_do_poll;
      got.do_release = out_do_release;
      got.do_fail    = out_do_fail;
      got.do_write   = out_do_write;
      got.target_id  = out_target_id;
      got.phase_now  = out_phase_now;
      sb.check_result(got);
    end
  end

  task automatic send(op_t op, logic [IdW-1:0] rid, logic [1:0] poll,
                      logic owner, logic queued);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_report_id     <= rid;
    in_poll_status   <= poll;
    in_owner_granted <= owner;
    in_write_queued  <= queued;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op, rid, poll, owner, queued);
  endtask

  task automatic run_tick(logic [1:0] poll, logic owner, logic queued);
    send(OP_RUN, IdW'($urandom_range(255)), poll, owner, queued);
  endtask

  task automatic send_random();
    int             r;
    op_t            op;
    logic [IdW-1:0] rid;
    logic [1:0]     poll;
    r    = $urandom_range(99);
    op   = r < 14 ? OP_REQUEST : r < 78 ? OP_RUN : r < 92 ? OP_TAKE : OP_NONE;
    rid  = ($urandom_range(7) == 0) ? '0 : IdW'($urandom_range(255));
    r    = $urandom_range(99);
    poll = r < 40 ? POLL_BUSY : r < 75 ? POLL_COMPLETE : r < 90 ? POLL_FAILED : POLL_ODD;
    send(op, rid, poll, $urandom_range(9) != 0, $urandom_range(9) != 0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int ph;
    int k;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // detached transport: refuse requests, ignore ticks
    send(OP_REQUEST, 8'd5, POLL_COMPLETE, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_TAKE, 8'd0, POLL_BUSY, 1'b0, 1'b0);
    send(OP_NONE, 8'hff, POLL_ODD, 1'b1, 1'b1);
    settle();

    write_reg(CFG_ATTACHED, 10'h3ff);
    write_reg(CFG_BUSY_LIMIT, '0);
    send(OP_REQUEST, 8'd0, POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_REQUEST, 8'hff, POLL_ODD, 1'b0, 1'b0);
    send(OP_REQUEST, 8'h01, POLL_BUSY, 1'b0, 1'b0);
    run_tick(POLL_COMPLETE, 1'b0, 1'b1);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b0);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_ODD, 1'b0, 1'b0);
    send(OP_REQUEST, 8'h42, POLL_BUSY, 1'b0, 1'b0);
    run_tick(POLL_BUSY, 1'b0, 1'b0);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_REQUEST, 8'h7e, POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_FAILED, 1'b1, 1'b1);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    run_tick(POLL_FAILED, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_TAKE, 8'hff, POLL_ODD, 1'b1, 1'b1);
    send(OP_TAKE, 8'h00, POLL_BUSY, 1'b0, 1'b0);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_NONE, 8'h00, POLL_BUSY, 1'b0, 1'b0);
    settle();

    // largest limit: run the busy counter into saturation before the timeout
    set_idling(3);
    write_reg(CFG_BUSY_LIMIT, COUNT_MAX);
    send(OP_REQUEST, 8'ha5, POLL_BUSY, 1'b0, 1'b0);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    n = 0;
    while (sb.phase == PH_PENDING) begin
      run_tick(POLL_BUSY, 1'b1, 1'b0);
      n++;
      if (n == 300) hold_left = 60;
      if (n == 600) settle();
    end
    run_tick(POLL_ODD, 1'b1, 1'b1);
    run_tick(POLL_BUSY, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    run_tick(POLL_COMPLETE, 1'b1, 1'b1);
    send(OP_TAKE, 8'h5a, POLL_COMPLETE, 1'b0, 1'b1);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      set_idling(ph % 4);
      write_reg(CFG_ATTACHED, {9'($urandom_range(511)), 1'(ph != 4)});
      write_reg(CFG_BUSY_LIMIT, (ph == 3) ? 10'd1000 : 10'(ph % 3));
      for (k = 0; k < 110; k++) begin
        send_random();
        if (ph == 2 && k == 50) hold_left = 80;
        if (ph == 1 && k == 55) settle();
      end
      settle();
    end

    $display("covered %0d transactions, %0d results: %0d token writes, %0d busy timeouts,",
             sb.n_ops, sb.n_results, sb.n_writes, sb.n_timeouts);
    $display("%0d acks taken, busy count peak %0d", sb.n_acks, sb.peak_busy);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cbwr_pkg.sv
design/callback_write_retry_fsm.sv
design/cbwr_checker.sv
test/testbench.sv
